// ----- sv/ttv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_pkg
// Shared types and constants of the triangle tangent vector core.
// ----------------------------------------------------------------------------
package ttv_pkg;

  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned JOB_Q_DEPTH       = 2;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef logic signed [32:0] delta_t;

  // one complete triangle, reduced to edge and texture deltas
  typedef struct packed {
    delta_t du1;
    delta_t dv1;
    delta_t du2;
    delta_t dv2;
    delta_t e1_x;
    delta_t e1_y;
    delta_t e1_z;
    delta_t e2_x;
    delta_t e2_y;
    delta_t e2_z;
  } job_t;

endpackage

// ----- sv/ttv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_front
// Takes corner transfers, holds corners 0 and 1 and turns corner 2 into a job.
// ----------------------------------------------------------------------------
module ttv_front (
  input  logic          clk_i,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [1:0]    corner_i,
  input  logic [31:0]   pos_x_i,
  input  logic [31:0]   pos_y_i,
  input  logic [31:0]   pos_z_i,
  input  logic [31:0]   tex_u_i,
  input  logic [31:0]   tex_v_i,
  input  logic          q_full_i,
  output logic          push_o,
  output ttv_pkg::job_t job_o
);
  import ttv_pkg::*;

  logic [31:0] p0_q [3];
  logic [31:0] p1_q [3];
  logic [31:0] t0_q [2];
  logic [31:0] t1_q [2];
  logic        take;

  assign s_ready_o = (corner_i != CORNER_2) || !q_full_i;
  assign take      = s_valid_i && s_ready_o;
  assign push_o    = take && (corner_i == CORNER_2);

  always_ff @(posedge clk_i) begin
    if (take && corner_i == CORNER_0) begin
      p0_q[0] <= pos_x_i;
      p0_q[1] <= pos_y_i;
      p0_q[2] <= pos_z_i;
      t0_q[0] <= tex_u_i;
      t0_q[1] <= tex_v_i;
    end
    if (take && corner_i == CORNER_1) begin
      p1_q[0] <= pos_x_i;
      p1_q[1] <= pos_y_i;
      p1_q[2] <= pos_z_i;
      t1_q[0] <= tex_u_i;
      t1_q[1] <= tex_v_i;
    end
  end

  function automatic delta_t sdiff(logic [31:0] a, logic [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  always_comb begin
    job_o.du1  = sdiff(t1_q[0], t0_q[0]);
    job_o.dv1  = sdiff(t1_q[1], t0_q[1]);
    job_o.du2  = sdiff(tex_u_i, t0_q[0]);
    job_o.dv2  = sdiff(tex_v_i, t0_q[1]);
    job_o.e1_x = sdiff(p1_q[0], p0_q[0]);
    job_o.e1_y = sdiff(p1_q[1], p0_q[1]);
    job_o.e1_z = sdiff(p1_q[2], p0_q[2]);
    job_o.e2_x = sdiff(pos_x_i, p0_q[0]);
    job_o.e2_y = sdiff(pos_y_i, p0_q[1]);
    job_o.e2_z = sdiff(pos_z_i, p0_q[2]);
  end

endmodule

// ----- sv/ttv_job_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_job_queue
// Short queue of triangle jobs between the front and the back.
// ----------------------------------------------------------------------------
module ttv_job_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ttv_pkg::job_t data_i,
  input  logic          pop_i,
  output ttv_pkg::job_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import ttv_pkg::*;

  localparam int unsigned PW = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(JOB_Q_DEPTH + 1);

  job_t          mem_q [JOB_Q_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == PW'(JOB_Q_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(JOB_Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i)  rd_q <= inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("job queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(JOB_Q_DEPTH))
    else $error("job queue count out of range");

endmodule

// ----- sv/ttv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_back
// Sequencer: products, sign fix, normalizing shift, squares, square root,
// three divisions and the output register.
// ----------------------------------------------------------------------------
module ttv_back #(
  parameter int unsigned OutFracBits = ttv_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  ttv_pkg::job_t job_i,
  output logic          pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [15:0]   tan_x_o,
  output logic [15:0]   tan_y_o,
  output logic [15:0]   tan_z_o,
  output logic          degenerate_o
);
  import ttv_pkg::*;

  localparam int unsigned NW  = 32 + OutFracBits;
  localparam int unsigned DCW = $clog2(NW);
  localparam int unsigned QW  = OutFracBits + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ABS  = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_DSET = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]         state_q;
  logic [3:0]         cnt_q;
  job_t               job_q;
  logic signed [65:0] prod_q;
  logic signed [66:0] acc_q [4];
  logic [66:0]        mag_q [3];
  logic [2:0]         neg_q;
  logic [63:0]        s_q, x_q, res_q, bit_q;
  logic [31:0]        r_q, rem_q;
  logic [NW-1:0]      num_q;
  logic [DCW-1:0]     dcnt_q;
  logic [QW-1:0]      quo_q;
  logic [1:0]         ci_q;
  logic [15:0]        tan_q [3];
  logic               deg_q;
  logic               out_valid_q;
  logic [15:0]        out_tan_q [3];
  logic               out_deg_q;

  logic signed [32:0] mul_a, mul_b;
  logic [2:0]         step;
  logic [1:0]         sq_idx;
  logic [66:0]        mag_or;
  logic [63:0]        trial;
  logic [NW-1:0]      num_d;
  logic [32:0]        dtry;
  logic [QW-1:0]      quo_d;
  logic [15:0]        sat;
  logic               degen;
  logic               out_load;

  assign step     = 3'(cnt_q - 4'd1);
  assign sq_idx   = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
  assign mag_or   = mag_q[0] | mag_q[1] | mag_q[2];
  assign trial    = res_q + bit_q;
  assign num_d    = (NW'(mag_q[ci_q][30:0]) << OutFracBits) + NW'(r_q >> 1);
  assign dtry     = {rem_q, num_q[dcnt_q]};
  assign quo_d    = {quo_q[QW-2:0], (dtry >= {1'b0, r_q})};
  assign sat      = (quo_d > QW'(32767)) ? 16'd32767 : 16'(quo_d);
  assign degen    = (acc_q[0] == '0) ||
                    (acc_q[1] == '0 && acc_q[2] == '0 && acc_q[3] == '0);
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_ready_i);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQ) begin
      mul_a = $signed({2'b00, mag_q[sq_idx][30:0]});
      mul_b = mul_a;
    end else begin
      case (cnt_q[2:0])
        3'd0: begin mul_a = job_q.du1; mul_b = job_q.dv2; end
        3'd1: begin mul_a = job_q.du2; mul_b = job_q.dv1; end
        3'd2: begin mul_a = job_q.dv2; mul_b = job_q.e1_x; end
        3'd3: begin mul_a = job_q.dv1; mul_b = job_q.e2_x; end
        3'd4: begin mul_a = job_q.dv2; mul_b = job_q.e1_y; end
        3'd5: begin mul_a = job_q.dv1; mul_b = job_q.e2_y; end
        3'd6: begin mul_a = job_q.dv2; mul_b = job_q.e1_z; end
        default: begin mul_a = job_q.dv1; mul_b = job_q.e2_z; end
      endcase
    end
  end

  assign pop_o = (state_q == S_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (pop_o) job_q <= job_i;
    if (state_q == S_MUL && cnt_q != 4'd0) begin
      acc_q[step[2:1]] <= step[0] ? acc_q[step[2:1]] - {prod_q[65], prod_q}
                                  : {prod_q[65], prod_q};
    end
    if (state_q == S_ABS) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= acc_q[i+1][66] ? 67'(-acc_q[i+1]) : acc_q[i+1];
        neg_q[i] <= (acc_q[i+1] != '0) && (acc_q[i+1][66] ^ acc_q[0][66]);
      end
    end
    if (state_q == S_NORM && mag_or[66:31] != '0) begin
      for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
    end
    if (state_q == S_SQ) begin
      if (cnt_q == 4'd1) s_q <= prod_q[63:0];
      else if (cnt_q != 4'd0) s_q <= s_q + prod_q[63:0];
      if (cnt_q == 4'd3) begin
        x_q   <= s_q + prod_q[63:0];
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
    end
    if (state_q == S_SQRT) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      if (bit_q == 64'd1) r_q <= (x_q >= trial) ? 32'((res_q >> 1) + bit_q)
                                                : 32'(res_q >> 1);
    end
    if (state_q == S_DSET) begin
      num_q  <= num_d;
      rem_q  <= 32'(num_d >> (OutFracBits + 1));
      quo_q  <= '0;
      dcnt_q <= DCW'(OutFracBits);
    end
    if (state_q == S_DIV) begin
      rem_q  <= (dtry >= {1'b0, r_q}) ? 32'(dtry - {1'b0, r_q}) : dtry[31:0];
      quo_q  <= quo_d;
      dcnt_q <= dcnt_q - DCW'(1);
      if (dcnt_q == '0) tan_q[ci_q] <= neg_q[ci_q] ? -sat : sat;
    end
    if (state_q == S_ABS) begin
      deg_q <= degen;
      if (degen) begin
        for (int i = 0; i < 3; i++) tan_q[i] <= '0;
      end
    end
    if (out_load) begin
      out_tan_q <= tan_q;
      out_deg_q <= deg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ci_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (pop_o) state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd8) state_q <= S_ABS;
        end
        S_ABS: begin
          cnt_q <= '0;
          if (degen)
            state_q <= S_EMIT;
          else
            state_q <= S_NORM;
        end
        S_NORM: begin
          if (mag_or[66:31] == '0) state_q <= S_SQ;
        end
        S_SQ: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd3) state_q <= S_SQRT;
        end
        S_SQRT: begin
          ci_q <= '0;
          if (bit_q == 64'd1) state_q <= S_DSET;
        end
        S_DSET: state_q <= S_DIV;
        S_DIV: begin
          if (dcnt_q == '0) begin
            ci_q    <= ci_q + 2'd1;
            state_q <= (ci_q == 2'd2) ? S_EMIT : S_DSET;
          end
        end
        S_EMIT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_valid_o    = out_valid_q;
  assign tan_x_o      = out_tan_q[0];
  assign tan_y_o      = out_tan_q[1];
  assign tan_z_o      = out_tan_q[2];
  assign degenerate_o = out_deg_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> r_q != '0)
    else $error("divide by zero root");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == S_MUL)
    else $error("job popped outside idle");
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_deg_q) |->
      (out_tan_q[0] == '0 && out_tan_q[1] == '0 && out_tan_q[2] == '0))
    else $error("degenerate result with nonzero tangent");

endmodule

// ----- sv/triangle_tangent_vector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_vector_core
// Per-triangle unit tangent from three corners (position and texcoord).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one corner per transfer; tuser is the corner number.
//   Corners 0 and 1 are stored; corner 2 completes a triangle and causes one
//   m_axis transfer with the unit tangent (Q1.OutFracBits) and a degenerate
//   flag. Corner code 3 is dropped.
//   Corners 0 and 1 are never held off. Corner 2 becomes a job in a
//   two-entry queue; the back sequencer works one job at a time: a pop,
//   the multiplies, a sign step, normalizing right shifts until all three
//   magnitudes fit in 31 bits, the squares, 32 square-root steps, three
//   divisions (each a set-up step and its quotient steps) and a hand-over;
//   a degenerate triangle goes from the sign step straight to the hand-over.
//   That sequencer sets the rate.
//   A stalled m_axis holds the result register; the sequencer continues with
//   the next job and waits only to hand over its result. When the queue is
//   full, corner 2 transfers are held off while corners 0 and 1 still pass.
//   Reset clears the queue, the sequencer and the output valid; stored
//   corners are undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_vector_core #(
  parameter int unsigned OutFracBits = ttv_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [1:0]   s_axis_tuser,  // corner
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // tan_x, tan_y, tan_z
  output logic         m_axis_tuser   // degenerate
);
  import ttv_pkg::*;

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;

  ttv_front u_front (
    .clk_i     (clk_i),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .corner_i  (s_axis_tuser),
    .pos_x_i   (s_axis_tdata[31:0]),
    .pos_y_i   (s_axis_tdata[63:32]),
    .pos_z_i   (s_axis_tdata[95:64]),
    .tex_u_i   (s_axis_tdata[127:96]),
    .tex_v_i   (s_axis_tdata[159:128]),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (job_in)
  );

  ttv_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ttv_back #(
    .OutFracBits (OutFracBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .tan_x_o      (m_axis_tdata[15:0]),
    .tan_y_o      (m_axis_tdata[31:16]),
    .tan_z_o      (m_axis_tdata[47:32]),
    .degenerate_o (m_axis_tuser)
  );

endmodule

// ----- bench/triangle_tangent_vector_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_vector_core_tb
// Self-checking bench for the tangent core. Corners stream in on s_axis from
// a queue of pending transfers; a behavioral tangent calculator predicts each
// result, and m_axis transfers are compared field by field in order.
// Both sides idle in random bursts; one long output stall fills the job queue.
// ----------------------------------------------------------------------------
module triangle_tangent_vector_core_tb;
  import ttv_pkg::*;

  localparam int FRAC = OUT_FRAC_BITS_DEF;
  localparam logic [1:0] CORNER_NONE = 2'd3;

  typedef struct {
    logic [1:0]         corner;
    logic signed [31:0] px, py, pz, tu, tv;
  } corner_t;

  typedef struct {
    logic [15:0] tx, ty, tz;
    logic        degen;
  } tangent_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  triangle_tangent_vector_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  corner_t  pending_corners[$];
  tangent_t expected_tangents[$];
  int       errors = 0;
  bit       calm = 1'b0;      // no idling in the last part
  bit       hold_long = 1'b0;
  bit       stall_req = 1'b0;
  bit       in_taken = 1'b0;

  // predictor state
  logic signed [31:0] held_p[6];
  logic signed [31:0] held_t[4];

  task automatic add_corner(corner_t c);
    pending_corners.insert(pending_corners.size(), c);
  endtask

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic tangent_t tangent_of(corner_t c);
    tangent_t           r;
    logic signed [33:0] du1, dv1, du2, dv2, e1, e2;
    logic signed [69:0] det, t[3];
    logic [69:0]        mag[3];
    logic [63:0]        a[3], s, rt, q;
    int                 len, sh;
    du1 = 34'(held_t[2]) - 34'(held_t[0]);
    dv1 = 34'(held_t[3]) - 34'(held_t[1]);
    du2 = 34'(c.tu) - 34'(held_t[0]);
    dv2 = 34'(c.tv) - 34'(held_t[1]);
    det = 70'(du1) * 70'(dv2) - 70'(du2) * 70'(dv1);
    for (int i = 0; i < 3; i++) begin
      e1 = 34'(held_p[3+i]) - 34'(held_p[i]);
      e2 = 34'(i == 0 ? c.px : i == 1 ? c.py : c.pz) - 34'(held_p[i]);
      t[i] = 70'(dv2) * 70'(e1) - 70'(dv1) * 70'(e2);
      if (det < 0) t[i] = -t[i];
      mag[i] = t[i] < 0 ? 70'(-t[i]) : 70'(t[i]);
    end
    len = 0;
    for (int i = 0; i < 3; i++)
      for (int b = 0; b < 70; b++)
        if (mag[i][b] && b + 1 > len) len = b + 1;
    r = '{tx: '0, ty: '0, tz: '0, degen: 1'b1};
    if (det == 0 || len == 0) return r;
    sh = len > 31 ? len - 31 : 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = 64'(mag[i] >> sh);
      s += a[i] * a[i];
    end
    rt = isqrt(s);
    r.degen = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FRAC) + (rt >> 1)) / rt;
      if (q > 32767) q = 32767;
      if (t[i] < 0) q = -q;
      if (i == 0) r.tx = q[15:0];
      else if (i == 1) r.ty = q[15:0];
      else r.tz = q[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_val(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
    endcase
  endfunction

  function automatic corner_t rnd_corner(logic [1:0] k, int mode);
    corner_t c;
    c.corner = k;
    c.px = rnd_val(mode); c.py = rnd_val(mode); c.pz = rnd_val(mode);
    c.tu = rnd_val(mode); c.tv = rnd_val(mode);
    return c;
  endfunction

  function automatic corner_t mk(logic [1:0] k, int x, int y, int z, int u, int v);
    corner_t c;
    c.corner = k; c.px = x; c.py = y; c.pz = z; c.tu = u; c.tv = v;
    return c;
  endfunction

  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
  end

  // driver
  int send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_taken) begin
        // hold the offered transfer
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_corners.size() > 0) begin
        corner_t c;
        c = pending_corners.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.corner;
        s_axis_tdata <= {c.tv, c.tu, c.pz, c.py, c.px};
        if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 11);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // predict on accepted input
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      corner_t c;
      c.corner = s_axis_tuser;
      {c.tv, c.tu, c.pz, c.py, c.px} = s_axis_tdata;
      case (c.corner) inside
        CORNER_0, CORNER_1: begin
          for (int i = 0; i < 3; i++)
            held_p[c.corner*3+i] = i == 0 ? c.px : i == 1 ? c.py : c.pz;
          held_t[c.corner*2] = c.tu;
          held_t[c.corner*2+1] = c.tv;
        end
        CORNER_2: expected_tangents.insert(expected_tangents.size(), tangent_of(c));
        default: ;
      endcase
    end
  end

  // receiver readiness
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_long) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // long receiver stall
  initial begin
    wait (stall_req);
    hold_long = 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_long = 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_tangents.size() == 0) begin
        $error("unexpected transfer tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        tangent_t e;
        e = expected_tangents.pop_front();
        if (m_axis_tdata[15:0] !== e.tx) begin
          $error("tan_x expected %h got %h", e.tx, m_axis_tdata[15:0]); errors++;
        end
        if (m_axis_tdata[31:16] !== e.ty) begin
          $error("tan_y expected %h got %h", e.ty, m_axis_tdata[31:16]); errors++;
        end
        if (m_axis_tdata[47:32] !== e.tz) begin
          $error("tan_z expected %h got %h", e.tz, m_axis_tdata[47:32]); errors++;
        end
        if (m_axis_tuser !== e.degen) begin
          $error("degenerate expected %b got %b", e.degen, m_axis_tuser); errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int mode;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: unit right triangle, degenerate cases, extremes, dropped code
    add_corner(mk(CORNER_0, 0, 0, 0, 0, 0));
    add_corner(mk(CORNER_1, 65536, 0, 0, 65536, 0));
    add_corner(mk(CORNER_2, 0, 65536, 0, 0, 65536));
    add_corner(mk(CORNER_NONE, -1, -1, -1, -1, -1));
    add_corner(mk(CORNER_2, 0, 0, 65536, 0, -65536));
    add_corner(mk(CORNER_2, 5, 5, 5, 131072, 0));
    add_corner(mk(CORNER_0, 7, 7, 7, 0, 0));
    add_corner(mk(CORNER_1, 7, 7, 7, 65536, 0));
    add_corner(mk(CORNER_2, 7, 7, 7, 0, 65536));
    add_corner(mk(CORNER_0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 32'h7FFFFFFF));
    add_corner(mk(CORNER_1, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000));
    add_corner(mk(CORNER_2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 32'h80000000));
    add_corner(mk(CORNER_2, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h80000000));
    add_corner(mk(CORNER_0, 0, 0, 0, 0, 0));
    add_corner(mk(CORNER_1, 1, 0, 0, 1, 0));
    add_corner(mk(CORNER_2, 0, 1, 0, 0, 1));

    // long output stall while triangles keep coming
    wait (pending_corners.size() == 0);
    stall_req = 1'b1;
    for (int i = 0; i < 8; i++) add_corner(rnd_corner(CORNER_2, 0));
    wait (hold_long);
    wait (!hold_long);

    // random: mostly well-formed triangles, some noise
    for (int n = 0; n < 2000; ) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 8) begin
        add_corner(rnd_corner(CORNER_0, mode));
        add_corner(rnd_corner(CORNER_1, mode));
        add_corner(rnd_corner(CORNER_2, mode));
        n += 3;
      end else begin
        add_corner(rnd_corner(2'($urandom_range(0, 3)), mode));
        n++;
      end
      if (n > 1700) calm = 1'b1;
      while (pending_corners.size() > 16) @(posedge clk_i);
    end
    calm = 1'b1;
    wait (pending_corners.size() == 0 && !s_axis_tvalid);
    wait (expected_tangents.size() == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_tangents.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
